[hdl/bmd_pkg.sv]
// Shared types and constants for the bounded message deque.
package bmd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed widths of the item fields
  localparam int OP_W = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W = 32;
  localparam int FILL_W = 5;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_POP_TAIL  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

endpackage

[hdl/bounded_message_deque.sv]
// Bounded message deque: top level with head/count control and slot memory.
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle unless the result is stalled; each item
// makes at most one slot memory access (a push writes, a pop reads).
// Reset (rst_n low, synchronous) empties the deque, sets capacity to 16 and
// drops any pending result. Slot contents are not cleared and need no pass.
module bounded_message_deque #(
  parameter int DEPTH      = bmd_pkg::DEPTH_DEF,
  parameter int WORD_WIDTH = bmd_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [bmd_pkg::CAP_W-1:0]     cfg_wr_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bmd_pkg::OP_W-1:0]      in_operation,
  input  logic [WORD_WIDTH-1:0]         in_topic,
  input  logic [WORD_WIDTH-1:0]         in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bmd_pkg::STATUS_W-1:0]  out_status,
  output logic [bmd_pkg::WORD_W-1:0]    out_topic_out,
  output logic [bmd_pkg::WORD_W-1:0]    out_data_out,
  output logic [bmd_pkg::FILL_W-1:0]    out_fill_level
);

  import bmd_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // wide enough for the count, the capacity register and head + count
  localparam int EXT_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int CP_W  = (WORD_WIDTH < WORD_W) ? WORD_WIDTH : WORD_W;
  localparam int MEM_W = 2 * WORD_WIDTH;

  // control state
  logic [CAP_W-1:0] cap_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic             pop_ok_r, pop_ok_nxt;
  logic [FILL_W-1:0] fill_r;

  // memory access
  logic             accept;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] pos;
  logic [MEM_W-1:0] rd_data;

  // decode helpers
  op_t              op;
  logic [EXT_W-1:0] count_ext, eff_cap, cap_ext;
  logic             full;
  logic [IDX_W-1:0] head_inc, head_dec;
  logic [IDX_W-1:0] tail_push_pos, tail_pop_pos;

  logic [WORD_W-1:0] topic_ext, data_ext;

  // Reduce a value below 2*DEPTH into the slot range: one compare-subtract.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [EXT_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = (v >= EXT_W'(DEPTH)) ? (v - EXT_W'(DEPTH)) : v;
    return r[IDX_W-1:0];
  endfunction

  // A result may wait on the output while a new item is taken, as long as
  // the waiting one leaves this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign op = op_t'(in_operation);

  // Effective capacity: zero reads as one, anything above the build depth
  // saturates to it.
  assign cap_ext   = EXT_W'(cap_r);
  assign count_ext = EXT_W'(count_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EXT_W'(1);
    end else if (cap_ext > EXT_W'(DEPTH)) begin
      eff_cap = EXT_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  // lowered capacity below the fill level still counts as full
  assign full = (count_ext >= eff_cap);

  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(head_r + 1'b1);
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(head_r - 1'b1);
  assign tail_push_pos = wrap_idx(EXT_W'(head_r) + count_ext);
  assign tail_pop_pos  = wrap_idx(EXT_W'(head_r) + count_ext - EXT_W'(1));

  // Request decode. Head and count move in the accept cycle, so the next
  // item sees them at once; a slot written at one edge is read no earlier
  // than the following cycle, hence no forwarding path is needed.
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    pos        = head_r;
    if (accept) begin
      case (op)
        OP_PUSH_TAIL, OP_PUSH_HEAD: begin
          // zero data is checked before fullness
          if (in_data == '0) begin
            status_nxt = ST_ZERO;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = CNT_W'(count_r + 1'b1);
            if (op == OP_PUSH_TAIL) begin
              pos = tail_push_pos;
            end else begin
              pos      = head_dec;
              head_nxt = head_dec;
            end
          end
        end
        OP_POP_HEAD, OP_POP_TAIL: begin
          if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            pop_ok_nxt = 1'b1;
            count_nxt  = CNT_W'(count_r - 1'b1);
            if (op == OP_POP_HEAD) begin
              pos      = head_r;
              head_nxt = head_inc;
            end else begin
              pos = tail_pop_pos;
            end
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
      fill_r   <= FILL_W'(EXT_W'(count_nxt));
    end
  end

  // Slot store: {topic, data} per entry. Its read register only loads on a
  // pop, so it holds while the result is stalled.
  bmd_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos),
    .wr_data ({in_topic, in_data}),
    .rd_en   (rd_en),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  // Fit stored words to the 32-bit result fields
  always_comb begin
    topic_ext = '0;
    data_ext  = '0;
    topic_ext[CP_W-1:0] = rd_data[WORD_WIDTH +: CP_W];
    data_ext[CP_W-1:0]  = rd_data[0 +: CP_W];
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_topic_out  = pop_ok_r ? topic_ext : '0;
  assign out_data_out   = pop_ok_r ? data_ext : '0;
  assign out_fill_level = fill_r;

endmodule

[hdl/bmd_mem.sv]
// Message slot store: one write port, one read port, registered read data.
module bmd_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/bmd_checker.sv]
// Port-level checks for the bounded message deque, bound to the top level.
module bmd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [bmd_pkg::OP_W-1:0]      in_operation,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bmd_pkg::STATUS_W-1:0]  out_status,
  input logic [bmd_pkg::WORD_W-1:0]    out_topic_out,
  input logic [bmd_pkg::WORD_W-1:0]    out_data_out,
  input logic [bmd_pkg::FILL_W-1:0]    out_fill_level
);

  import bmd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_topic_out) && $stable(out_data_out) && $stable(out_fill_level))
    else $error("stalled result changed");

  // every accepted item shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // failed requests carry no message
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_topic_out == '0 && out_data_out == '0)
    else $error("message words on a failed request");

  // an empty refusal leaves nothing held
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_fill_level == '0)
    else $error("empty status with messages held");

  // neither a zero-data nor a full refusal shows from a pop
  a_zero_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation[1] |=> out_status != ST_ZERO
      && out_status != ST_FULL)
    else $error("pop gave a push status");

endmodule

bind bounded_message_deque bmd_checker u_bmd_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the bounded message deque: directed rows, then random phases.
module tb_top;
  import bmd_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_ROWS = 23;
  localparam int NUM_PHASES = 20;
  localparam int ITEMS_PER_PHASE = 55;

  // Capacity written at the start of the first random phases; later ones draw it.
  localparam logic [CAP_W-1:0] CAP_PLAN [8] = '{5'd16, 5'd1, 5'd0, 5'd31,
                                                5'd17, 5'd2, 5'd15, 5'd8};
  // Share of pushes per phase, in percent: fill-heavy, balanced, drain-heavy, mixed.
  localparam int PUSH_BIAS [4] = '{85, 50, 20, 70};

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] topic;
    logic [WORD_W-1:0] data;
    logic [FILL_W-1:0] fill;
  } deque_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One directed row. A capacity row carries the new value in data.
  typedef struct packed {
    row_kind_t         kind;
    op_t               op;
    logic [WORD_W-1:0] topic;
    logic [WORD_W-1:0] data;
    bit                check;
    deque_result_t     result;
  } stim_row_t;

  localparam deque_result_t NO_RESULT = '0;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CAP_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation;
  logic [WORD_W-1:0]   in_topic;
  logic [WORD_W-1:0]   in_data;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0]   out_topic_out;
  logic [WORD_W-1:0]   out_data_out;
  logic [FILL_W-1:0]   out_fill_level;

  // Predicted deque contents and control
  logic [WORD_W-1:0] q_topic [DEPTH];
  logic [WORD_W-1:0] q_data [DEPTH];
  logic [3:0]        q_head;
  logic [FILL_W-1:0] q_held;
  logic [CAP_W-1:0]  q_cap;

  deque_result_t pending_results [$];

  // Set by the request driver for the item on the wire; read at acceptance
  bit            row_check;
  deque_result_t row_result;
  // req_taken is updated every rising edge, quiet_phase by the stimulus; drivers read both at the falling edge
  bit            req_taken;
  bit            quiet_phase;

  int n_errors;
  int n_sent;
  int n_results;
  int n_cfg;
  int status_seen [4];
  int cycle_count;

  // Directed rows: empty pops, zero data, extremes of the words, head wrap,
  // capacity zero and above the built depth, capacity lowered below the fill.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_REQ, OP_POP_HEAD,  32'h0, 32'h0, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 5'd0}},
    '{ROW_REQ, OP_POP_TAIL,  '1, '1, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 5'd0}},
    '{ROW_REQ, OP_PUSH_TAIL, '1, 32'h0, 1'b1, '{ST_ZERO, 32'h0, 32'h0, 5'd0}},
    '{ROW_REQ, OP_PUSH_HEAD, 32'h1234_5678, 32'h0, 1'b1, '{ST_ZERO, 32'h0, 32'h0, 5'd0}},
    '{ROW_REQ, OP_PUSH_TAIL, 32'h0, 32'h1, 1'b1, '{ST_OK, 32'h0, 32'h0, 5'd1}},
    '{ROW_REQ, OP_PUSH_TAIL, '1, '1, 1'b1, '{ST_OK, 32'h0, 32'h0, 5'd2}},
    // head steps back past slot zero
    '{ROW_REQ, OP_PUSH_HEAD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd3}},
    '{ROW_REQ, OP_POP_TAIL,  32'h0, 32'h0, 1'b1, '{ST_OK, '1, '1, 5'd2}},
    '{ROW_REQ, OP_POP_HEAD,  32'h0, 32'h0, 1'b1,
      '{ST_OK, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd1}},
    '{ROW_REQ, OP_POP_HEAD,  32'h0, 32'h0, 1'b1, '{ST_OK, 32'h0, 32'h1, 5'd0}},
    // capacity zero behaves as one slot
    '{ROW_CFG, OP_PUSH_TAIL, 32'h0, 32'd0, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_PUSH_HEAD, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{ST_OK, 32'h0, 32'h0, 5'd1}},
    '{ROW_REQ, OP_PUSH_TAIL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      '{ST_FULL, 32'h0, 32'h0, 5'd1}},
    // zero data wins over full
    '{ROW_REQ, OP_PUSH_TAIL, 32'h0, 32'h0, 1'b1, '{ST_ZERO, 32'h0, 32'h0, 5'd1}},
    // above the built depth saturates
    '{ROW_CFG, OP_PUSH_TAIL, 32'h0, 32'd31, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_PUSH_TAIL, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_PUSH_HEAD, 32'h1357_9BDF, 32'h2468_ACE0, 1'b0, NO_RESULT},
    // capacity below the fill: held items stay poppable
    '{ROW_CFG, OP_PUSH_TAIL, 32'h0, 32'd1, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_PUSH_HEAD, 32'h1, 32'h1, 1'b1, '{ST_FULL, 32'h0, 32'h0, 5'd3}},
    '{ROW_REQ, OP_POP_TAIL,  32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_POP_HEAD,  32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_POP_HEAD,  32'h0, 32'h0, 1'b0, NO_RESULT},
    '{ROW_REQ, OP_POP_TAIL,  32'h0, 32'h0, 1'b1, '{ST_EMPTY, 32'h0, 32'h0, 5'd0}}
  };

  bounded_message_deque dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_topic       (in_topic),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_topic_out  (out_topic_out),
    .out_data_out   (out_data_out),
    .out_fill_level (out_fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Slots actually usable: zero counts as one, anything above the depth is the depth.
  function automatic logic [CAP_W-1:0] usable_slots();
    if (q_cap == '0) return CAP_W'(1);
    if (q_cap > DEPTH) return CAP_W'(DEPTH);
    return q_cap;
  endfunction

  // Applies one request to the predicted deque and returns its result.
  function automatic deque_result_t apply_request(op_t op, logic [WORD_W-1:0] topic,
                                                  logic [WORD_W-1:0] data);
    deque_result_t res;
    logic [3:0] pos;
    res = NO_RESULT;
    if (op == OP_PUSH_TAIL || op == OP_PUSH_HEAD) begin
      if (data == '0) begin
        res.status = ST_ZERO;
      end else if (q_held >= usable_slots()) begin
        res.status = ST_FULL;
      end else begin
        if (op == OP_PUSH_TAIL) begin
          pos = 4'((q_head + q_held) % DEPTH);
        end else begin
          q_head = 4'((q_head + DEPTH - 1) % DEPTH);
          pos = q_head;
        end
        q_topic[pos] = topic;
        q_data[pos] = data;
        q_held++;
      end
    end else if (q_held == '0) begin
      res.status = ST_EMPTY;
    end else begin
      if (op == OP_POP_HEAD) begin
        pos = q_head;
        q_head = 4'((q_head + 1) % DEPTH);
      end else begin
        pos = 4'((q_head + q_held - 1) % DEPTH);
      end
      res.topic = q_topic[pos];
      res.data = q_data[pos];
      q_held--;
    end
    res.fill = q_held;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch at result %0d: %s got %h, expected %h", n_results, what, got, want);
    n_errors++;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Edge words turn up more often than a flat draw would give them.
  function automatic logic [WORD_W-1:0] draw_word();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Result checker and predictor update, both on the rising edge.
  always @(posedge clk) begin : deque_monitor
    deque_result_t got;
    deque_result_t want;
    if (!rst_n) begin
      q_head = '0;
      q_held = '0;
      q_cap = CAP_RESET;
      req_taken = 1'b0;
      foreach (q_topic[k]) begin
        q_topic[k] = '0;
        q_data[k] = '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status_t'(out_status), out_topic_out, out_data_out, out_fill_level};
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with none expected, status", WORD_W'(got.status), '0);
        end else begin
          want = pending_results.pop_front();
          status_seen[got.status]++;
          if (got.status !== want.status) begin
            report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
          end
          if (got.topic !== want.topic) report_mismatch("topic", got.topic, want.topic);
          if (got.data !== want.data) report_mismatch("data", got.data, want.data);
          if (got.fill !== want.fill) begin
            report_mismatch("fill level", WORD_W'(got.fill), WORD_W'(want.fill));
          end
        end
      end
      if (cfg_wr_en) q_cap = cfg_wr_data;
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        want = apply_request(op_t'(in_operation), in_topic, in_data);
        // typed rows override the predictor, which still tracks the state
        pending_results.push_back(row_check ? row_result : want);
      end
    end
  end

  // Result side stall: runs of random length, none during quiet phases.
  initial begin : result_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = quiet_phase ? 0 : pick_gap();
      if (n == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("[bounded_message_deque] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no second assignment.
  task automatic send_request(input op_t op, input logic [WORD_W-1:0] topic,
                              input logic [WORD_W-1:0] data, input bit check,
                              input deque_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_topic <= topic;
    in_data <= data;
    row_check = check;
    row_result = want;
    do @(negedge clk); while (!req_taken);
    n_sent++;
  endtask

  // Every item gives a result, so an empty store of expectations means idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  initial begin : stimulus
    op_t op;
    logic [CAP_W-1:0] cap;
    int push_pct;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_operation = '0;
    in_topic = '0;
    in_data = '0;
    row_check = 1'b0;
    row_result = NO_RESULT;
    quiet_phase = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_capacity(directed_rows[r].data[CAP_W-1:0]);
      end else begin
        send_request(directed_rows[r].op, directed_rows[r].topic, directed_rows[r].data,
                     directed_rows[r].check, directed_rows[r].result);
      end
    end

    // Random phases: each starts from idle with a new capacity; the fill level
    // carries over, so a smaller capacity often lands below it.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      cap = (ph < 8) ? CAP_PLAN[ph] : CAP_W'($urandom_range(0, 31));
      write_capacity(cap);
      push_pct = PUSH_BIAS[ph % 4];
      quiet_phase = (ph % 5 == 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = ($urandom_range(0, 1) == 0) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
        end else begin
          op = ($urandom_range(0, 1) == 0) ? OP_POP_HEAD : OP_POP_TAIL;
        end
        send_request(op, draw_word(), draw_word(), 1'b0, NO_RESULT);
      end
    end
    quiet_phase = 1'b0;

    wait_idle();
    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered, count", pending_results.size(), '0);
    end

    $display("covered %0d requests and %0d results over %0d capacity writes",
             n_sent, n_results, n_cfg);
    $display("results by status: ok %0d, full %0d, empty %0d, zero data %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_ZERO]);
    if (n_errors == 0) begin
      $display("[bounded_message_deque] OK");
    end else begin
      $display("[bounded_message_deque] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bmd_pkg.sv
hdl/bmd_mem.sv
hdl/bounded_message_deque.sv
hdl/bmd_checker.sv
sim/tb_top.sv
